// File: hw/rtl/diag_session_security_server_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the diagnostic session and security server
// Shared forms for the concurrent checks; each expects i_clk and i_rst_n.
// ---------------------------------------------------------------------------
`ifndef DIAG_SESSION_SECURITY_SERVER_TOP_ASSERT_SVH
`define DIAG_SESSION_SECURITY_SERVER_TOP_ASSERT_SVH

// condition must never hold
`define DSSS_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define DSSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/dsss_pkg.sv
// ---------------------------------------------------------------------------
// Diagnostic session and security server package
// Types, service codes, response codes and helpers shared by all modules.
// ---------------------------------------------------------------------------
package dsss_pkg;

    localparam int TIMER_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_L1_MASK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L3_MASK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_TCKS = 3'd4;

    localparam logic [7:0] SID_SESSION  = 8'h10;
    localparam logic [7:0] SID_SECURITY = 8'h27;
    localparam logic [7:0] SID_TESTER   = 8'h3E;
    localparam logic [7:0] SID_RD_DID   = 8'h22;
    localparam logic [7:0] SID_WR_DID   = 8'h2E;
    localparam logic [7:0] SID_CLR_DTC  = 8'h14;
    localparam logic [7:0] SID_RD_DTC   = 8'h19;

    localparam logic [7:0] RSP_NEG      = 8'h7F;
    localparam logic [7:0] RSP_SESSION  = 8'h50;
    localparam logic [7:0] RSP_SECURITY = 8'h67;
    localparam logic [7:0] RSP_TESTER   = 8'h7E;

    localparam logic [7:0] NRC_SRV_NOT_SUP = 8'h11;
    localparam logic [7:0] NRC_SUB_NOT_SUP = 8'h12;
    localparam logic [7:0] NRC_BAD_LEN     = 8'h13;
    localparam logic [7:0] NRC_BAD_KEY     = 8'h35;
    localparam logic [7:0] NRC_LOCKED      = 8'h37;

    localparam logic [7:0] SUB_MASK    = 8'h7F;
    localparam logic [7:0] SUB_SEED_L1 = 8'h01;
    localparam logic [7:0] SUB_KEY_L1  = 8'h02;
    localparam logic [7:0] SUB_SEED_L3 = 8'h03;
    localparam logic [7:0] SUB_KEY_L3  = 8'h04;

    localparam logic [1:0] SESS_DEFAULT = 2'd1;
    localparam logic [1:0] SESS_LAST    = 2'd3;
    localparam logic [1:0] SEC_LOCKED   = 2'd0;
    localparam logic [1:0] SEC_LEVEL1   = 2'd1;
    localparam logic [1:0] SEC_LEVEL3   = 2'd3;

    localparam logic [2:0] LEN_MAX = 3'd6;
    localparam logic [2:0] LEN_SUB = 3'd2;
    localparam logic [2:0] LEN_NEG = 3'd3;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_TOUCH,
        OP_SESSION,
        OP_SECURITY,
        OP_TESTER,
        OP_UNKNOWN
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [2:0]  len;
        logic [7:0]  sid;
        logic [7:0]  sub;
        logic [31:0] key;
        logic [31:0] seed;
    } t_item;

    typedef struct packed {
        logic [31:0] l1_mask;
        logic [31:0] l3_mask;
        logic [15:0] timeout;
        logic [7:0]  max_att;
        logic [15:0] lock_ticks;
    } t_cfg;

    function automatic logic [47:0] f_neg(input logic [7:0] sid, input logic [7:0] code);
        f_neg = {RSP_NEG, sid, code, 24'h0};
    endfunction

endpackage

// File: hw/rtl/dsss_front.sv
// ---------------------------------------------------------------------------
// Request front end
// Accept beats, saturate the length and classify the service into an op.
// ---------------------------------------------------------------------------
module dsss_front (
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic [2:0]         i_req_len,
    input  logic [7:0]         i_service_id,
    input  logic [7:0]         i_sub_function,
    input  logic [31:0]        i_key_value,
    input  logic [31:0]        i_fresh_seed,
    input  logic               i_q_full,
    output logic               o_push,
    output dsss_pkg::t_item    o_item
);
    import dsss_pkg::*;

    logic [2:0] s_len;

    assign s_len   = (i_req_len > LEN_MAX) ? LEN_MAX : i_req_len;
    assign o_ready = !i_q_full;
    // drop empty requests here
    assign o_push  = i_valid && !i_q_full && (i_func || (s_len != 3'd0));

    always_comb begin
        o_item.len  = s_len;
        o_item.sid  = i_service_id;
        o_item.sub  = i_sub_function;
        o_item.key  = i_key_value;
        o_item.seed = i_fresh_seed;
        if (i_func) begin
            o_item.op = OP_TICK;
        end else begin
            case (i_service_id)
                SID_SESSION:  o_item.op = OP_SESSION;
                SID_SECURITY: o_item.op = OP_SECURITY;
                SID_TESTER:   o_item.op = OP_TESTER;
                SID_RD_DID,
                SID_WR_DID,
                SID_CLR_DTC,
                SID_RD_DTC:   o_item.op = OP_TOUCH;
                default:      o_item.op = OP_UNKNOWN;
            endcase
        end
    end

endmodule

// File: hw/rtl/dsss_queue.sv
// ---------------------------------------------------------------------------
// Op queue
// Short FIFO between the front end and the execution back end.
// ---------------------------------------------------------------------------
`include "diag_session_security_server_top_assert.svh"

module dsss_queue #(
    parameter int DEPTH = dsss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dsss_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output dsss_pkg::t_item o_item
);
    import dsss_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    `DSSS_ASSERT_NEVER(a_cnt_bound, r_cnt > CNT_FULL, "queue count beyond depth")
    `DSSS_ASSERT_NEVER(a_pop_empty, i_pop && (r_cnt == '0), "pop from empty queue")
    `DSSS_ASSERT_NEXT(a_cnt_grow, i_push && !i_pop, r_cnt == $past(r_cnt) + 1'b1,
        "queue count did not advance on push")

endmodule

// File: hw/rtl/dsss_back.sv
// ---------------------------------------------------------------------------
// Execution back end
// Carry out ops against session and security state, register the response.
// ---------------------------------------------------------------------------
`include "diag_session_security_server_top_assert.svh"

module dsss_back #(
    parameter int TIMER_BITS = dsss_pkg::TIMER_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dsss_pkg::t_cfg  i_cfg,
    input  logic            i_q_valid,
    input  dsss_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [2:0]      o_rsp_len,
    output logic [47:0]     o_rsp_data,
    output logic [1:0]      o_session_now,
    output logic [1:0]      o_security_now
);
    import dsss_pkg::*;

    localparam int TW = TIMER_BITS;
    localparam int CW = (TW > 16) ? TW : 16;
    localparam logic [TW-1:0] TMR_MAX = {TW{1'b1}};

    logic [1:0]    r_session, n_session;
    logic [1:0]    r_sec, n_sec;
    logic [31:0]   r_seed, n_seed;
    logic [TW-1:0] r_stimer, n_stimer;
    logic [7:0]    r_fails, n_fails;
    logic [TW-1:0] r_lock, n_lock;

    logic          r_out_valid, n_out_valid;
    logic [2:0]    r_rsp_len, n_rsp_len;
    logic [47:0]   r_rsp_data, n_rsp_data;
    logic [1:0]    r_sess_out, n_sess_out;
    logic [1:0]    r_sec_out, n_sec_out;

    logic          s_has_rsp;
    logic          s_take;
    logic [TW-1:0] s_stimer_inc;
    logic [7:0]    s_fails_inc;
    logic [31:0]   s_t3;
    logic [31:0]   s_expect;
    logic [7:0]    s_sess_sub;
    logic [CW-1:0] s_lock_ext;
    logic [TW-1:0] s_lock_load;

    assign s_has_rsp    = (i_item.op != OP_TICK) && (i_item.op != OP_TOUCH);
    assign s_take       = !r_out_valid || i_ready;
    assign o_pop        = i_q_valid && (!s_has_rsp || s_take);

    assign s_stimer_inc = (r_stimer != TMR_MAX) ? r_stimer + 1'b1 : r_stimer;
    assign s_fails_inc  = (r_fails != 8'hFF) ? r_fails + 1'b1 : r_fails;
    assign s_t3         = r_seed ^ i_cfg.l3_mask;
    assign s_expect     = (i_item.sub == SUB_KEY_L1) ? (r_seed ^ i_cfg.l1_mask)
                                                     : {s_t3[23:0], s_t3[31:24]};
    assign s_sess_sub   = i_item.sub & SUB_MASK;
    assign s_lock_ext   = CW'(i_cfg.lock_ticks);
    assign s_lock_load  = (s_lock_ext > CW'(TMR_MAX)) ? TMR_MAX : s_lock_ext[TW-1:0];

    always_comb begin
        n_session  = r_session;
        n_sec      = r_sec;
        n_seed     = r_seed;
        n_stimer   = r_stimer;
        n_fails    = r_fails;
        n_lock     = r_lock;
        n_rsp_len  = LEN_NEG;
        n_rsp_data = f_neg(i_item.sid, NRC_SRV_NOT_SUP);
        if (o_pop) begin
            case (i_item.op)
                OP_TICK: begin
                    if (r_session != SESS_DEFAULT) begin
                        n_stimer = s_stimer_inc;
                        if (CW'(s_stimer_inc) >= CW'(i_cfg.timeout)) begin
                            n_session = SESS_DEFAULT;
                            n_sec     = SEC_LOCKED;
                            n_stimer  = '0;
                        end
                    end
                    if (r_lock != '0) begin
                        n_lock = r_lock - 1'b1;
                    end
                end
                OP_TOUCH: begin
                    n_stimer = '0;
                end
                OP_SESSION: begin
                    n_stimer = '0;
                    if (i_item.len < LEN_SUB) begin
                        n_rsp_data = f_neg(SID_SESSION, NRC_BAD_LEN);
                    end else if (s_sess_sub < 8'(SESS_DEFAULT) ||
                                 s_sess_sub > 8'(SESS_LAST)) begin
                        n_rsp_data = f_neg(SID_SESSION, NRC_SUB_NOT_SUP);
                    end else begin
                        n_session  = s_sess_sub[1:0];
                        n_sec      = SEC_LOCKED;
                        n_rsp_len  = LEN_SUB;
                        n_rsp_data = {RSP_SESSION, s_sess_sub, 32'h0};
                    end
                end
                OP_SECURITY: begin
                    n_stimer = '0;
                    if (i_item.len < LEN_SUB) begin
                        n_rsp_data = f_neg(SID_SECURITY, NRC_BAD_LEN);
                    end else if (r_lock != '0) begin
                        n_rsp_data = f_neg(SID_SECURITY, NRC_LOCKED);
                    end else if (i_item.sub == SUB_SEED_L1 || i_item.sub == SUB_SEED_L3) begin
                        n_seed     = i_item.seed | 32'h1;
                        n_rsp_len  = LEN_MAX;
                        n_rsp_data = {RSP_SECURITY, i_item.sub, i_item.seed[31:1], 1'b1};
                    end else if (i_item.sub == SUB_KEY_L1 || i_item.sub == SUB_KEY_L3) begin
                        if (i_item.len < LEN_MAX) begin
                            n_rsp_data = f_neg(SID_SECURITY, NRC_BAD_LEN);
                        end else if (i_item.key == s_expect) begin
                            n_sec      = (i_item.sub == SUB_KEY_L1) ? SEC_LEVEL1 : SEC_LEVEL3;
                            n_fails    = '0;
                            n_rsp_len  = LEN_SUB;
                            n_rsp_data = {RSP_SECURITY, i_item.sub, 32'h0};
                        end else begin
                            n_fails = s_fails_inc;
                            if (s_fails_inc >= i_cfg.max_att) begin
                                n_lock  = s_lock_load;
                                n_fails = '0;
                            end
                            n_rsp_data = f_neg(SID_SECURITY, NRC_BAD_KEY);
                        end
                    end else begin
                        n_rsp_data = f_neg(SID_SECURITY, NRC_SUB_NOT_SUP);
                    end
                end
                OP_TESTER: begin
                    n_stimer   = '0;
                    n_rsp_len  = LEN_SUB;
                    n_rsp_data = {RSP_TESTER,
                                  (i_item.len >= LEN_SUB) ? s_sess_sub : 8'h0, 32'h0};
                end
                default: begin
                    n_stimer = '0;
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        n_sess_out  = r_sess_out;
        n_sec_out   = r_sec_out;
        if (o_pop && s_has_rsp) begin
            n_out_valid = 1'b1;
            n_sess_out  = n_session;
            n_sec_out   = n_sec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session   <= SESS_DEFAULT;
            r_sec       <= SEC_LOCKED;
            r_seed      <= '0;
            r_stimer    <= '0;
            r_fails     <= '0;
            r_lock      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_session   <= n_session;
            r_sec       <= n_sec;
            r_seed      <= n_seed;
            r_stimer    <= n_stimer;
            r_fails     <= n_fails;
            r_lock      <= n_lock;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && s_has_rsp) begin
            r_rsp_len  <= n_rsp_len;
            r_rsp_data <= n_rsp_data;
        end
        r_sess_out <= n_sess_out;
        r_sec_out  <= n_sec_out;
    end

    assign o_valid        = r_out_valid;
    assign o_rsp_len      = r_rsp_len;
    assign o_rsp_data     = r_rsp_data;
    assign o_session_now  = r_sess_out;
    assign o_security_now = r_sec_out;

    `DSSS_ASSERT_NEVER(a_sess_zero, r_session == 2'd0, "session register holds zero")
    `DSSS_ASSERT_NEVER(a_sec_two, r_sec == 2'd2, "security level two unlocked")
    `DSSS_ASSERT_NEVER(a_lock_fails, (r_lock != '0) && (r_fails != '0),
        "failed count moved during lockout")
    `DSSS_ASSERT_NEXT(a_rsp_load, o_pop && s_has_rsp, r_out_valid,
        "served op left no response")

endmodule

// File: hw/rtl/diag_session_security_server_top.sv
// Path: an accepted request is queued, then popped and its response registered.
// Throughput: one beat per cycle while o_ready is high; one queued op retires a
// cycle unless a response waits on i_ready, as the output register frees on the
// edge its response is taken. Ticks and DID/DTC services give no response beat.
// Reset: synchronous, active low; session default, security locked, timers,
// counters and configuration back to their reset values, queue empty.
// ---------------------------------------------------------------------------
// Diagnostic session and security server, top level
// Configuration registers, front end, op queue and execution back end.
// ---------------------------------------------------------------------------
module diag_session_security_server_top #(
    parameter int TIMER_BITS  = dsss_pkg::TIMER_BITS_DEF,
    parameter int QUEUE_DEPTH = dsss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dsss_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dsss_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_func,
    input  logic [2:0]                        i_req_len,
    input  logic [7:0]                        i_service_id,
    input  logic [7:0]                        i_sub_function,
    input  logic [31:0]                       i_key_value,
    input  logic [31:0]                       i_fresh_seed,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [2:0]                        o_rsp_len,
    output logic [47:0]                       o_rsp_data,
    output logic [1:0]                        o_session_now,
    output logic [1:0]                        o_security_now
);
    import dsss_pkg::*;

    t_cfg  r_cfg, n_cfg;
    t_item s_front_item;
    t_item s_q_item;
    logic  s_push;
    logic  s_q_full;
    logic  s_q_valid;
    logic  s_pop;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_L1_MASK:   n_cfg.l1_mask    = i_cfg_data;
                CFG_L3_MASK:   n_cfg.l3_mask    = i_cfg_data;
                CFG_TIMEOUT:   n_cfg.timeout    = i_cfg_data[15:0];
                CFG_MAX_ATT:   n_cfg.max_att    = i_cfg_data[7:0];
                CFG_LOCK_TCKS: n_cfg.lock_ticks = i_cfg_data[15:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.l1_mask    <= '0;
            r_cfg.l3_mask    <= '0;
            r_cfg.timeout    <= 16'd500;
            r_cfg.max_att    <= 8'd3;
            r_cfg.lock_ticks <= 16'd1000;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    dsss_front u_front (
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_req_len      (i_req_len),
        .i_service_id   (i_service_id),
        .i_sub_function (i_sub_function),
        .i_key_value    (i_key_value),
        .i_fresh_seed   (i_fresh_seed),
        .i_q_full       (s_q_full),
        .o_push         (s_push),
        .o_item         (s_front_item)
    );

    dsss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_item  (s_front_item),
        .o_full  (s_q_full),
        .o_valid (s_q_valid),
        .i_pop   (s_pop),
        .o_item  (s_q_item)
    );

    dsss_back #(
        .TIMER_BITS (TIMER_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (s_q_valid),
        .i_item         (s_q_item),
        .o_pop          (s_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_rsp_len      (o_rsp_len),
        .o_rsp_data     (o_rsp_data),
        .o_session_now  (o_session_now),
        .o_security_now (o_security_now)
    );

endmodule
